FILE: src/sample_adaptive_golomb_encoder_core_macros.svh
`ifndef SAMPLE_ADAPTIVE_GOLOMB_ENCODER_CORE_MACROS_SVH
`define SAMPLE_ADAPTIVE_GOLOMB_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SAGE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sage: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SAGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sage: next-cycle check failed");

`endif

FILE: src/sage_pkg.sv
package sage_pkg;

  localparam int SAGE_MAX_BANDS = 256;

  localparam int DELTA_W = 16;
  localparam int BAND_W  = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 6;
  localparam int ACC_W   = 32;
  localparam int CNT_W   = 17;

  typedef enum logic [2:0] {
    CFG_SAMPLE_DEPTH   = 3'd0,
    CFG_UNARY_LIMIT    = 3'd1,
    CFG_COUNTER_BITS   = 3'd2,
    CFG_INIT_COUNT_EXP = 3'd3,
    CFG_ACC_INIT_CONST = 3'd4,
    CFG_BAND_COUNT     = 3'd5
  } cfg_idx_t;

  // Register values, already saturated into their legal ranges.
  typedef struct packed {
    logic [4:0] depth;
    logic [5:0] umax;
    logic [4:0] cbits;
    logic [4:0] ice;
    logic [4:0] kz;
    logic [8:0] band_count;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
    logic [ACC_W-1:0]  acc_nxt;
    logic [CNT_W-1:0]  cnt_nxt;
  } krn_out_t;

endpackage

FILE: src/sage_acc_mem.sv
module sage_acc_mem
  import sage_pkg::*;
#(
  parameter int DEPTH = SAGE_MAX_BANDS,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [ACC_W-1:0] wr_data,
  output logic [ACC_W-1:0] rd_data
);

  logic [ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [AW-1:0]    rd_addr_r;
  logic [ACC_W-1:0] rdata_r;
  logic [AW-1:0]    wb_addr_r;
  logic [ACC_W-1:0] wb_data_r;
  logic             wb_vld_r;

  // write back always goes to the entry last read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr_r <= rd_addr_r;
      wb_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      wb_vld_r  <= 1'b0;
      rd_addr_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[rd_addr_r] <= 1'b1;
        wb_vld_r         <= 1'b1;
      end
      if (rd_en) begin
        rd_addr_r <= rd_addr;
      end
    end
  end

  // forward the latest write; entries never written read as zero
  always_comb begin
    if (wb_vld_r && (wb_addr_r == rd_addr_r)) begin
      rd_data = wb_data_r;
    end else if (vld_r[rd_addr_r]) begin
      rd_data = rdata_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: src/sage_kernel.sv
module sage_kernel
  import sage_pkg::*;
(
  input  cfg_t               cfg,
  input  logic [DELTA_W-1:0] delta,
  input  logic               first_pixel,
  input  logic               last_band,
  input  logic [ACC_W-1:0]   acc,
  input  logic [CNT_W-1:0]   cnt,
  output krn_out_t           res
);

  logic [22:0]        prod;
  logic [ACC_W:0]     limit;
  logic [ACC_W:0]     scaled;
  logic [3:0]         top;
  logic [3:0]         k;
  logic [DELTA_W-1:0] dmask;
  logic [DELTA_W-1:0] value;
  logic [DELTA_W-1:0] u;
  logic [DELTA_W-1:0] kmask;
  logic               esc;
  logic [ACC_W:0]     sum;
  logic [ACC_W+1:0]   sum_rnd;
  logic [CNT_W-1:0]   cmax;
  logic [CNT_W-1:0]   cnt_inc;
  logic [23:0]        base;
  logic [39:0]        init_wide;

  // k: largest shift with cnt << k still within acc + 49*cnt/128
  always_comb begin
    prod  = 23'({cnt, 5'b0}) + 23'({cnt, 4'b0}) + 23'(cnt);
    limit = (ACC_W+1)'(acc) + (ACC_W+1)'(prod[22:7]);
    top   = (cfg.depth >= 5'd2) ? 4'(cfg.depth - 5'd2) : 4'd0;
    k     = 4'd0;
    scaled = '0;
    for (int i = 1; i <= 14; i++) begin
      scaled = (ACC_W+1)'(cnt) << i;
      if ((4'(i) <= top) && (scaled <= limit)) begin
        k = 4'(i);
      end
    end
  end

  always_comb begin
    dmask = DELTA_W'((17'd1 << cfg.depth) - 17'd1);
    value = delta & dmask;
    u     = value >> k;
    esc   = u >= DELTA_W'(cfg.umax);
    kmask = DELTA_W'((17'd1 << k) - 17'd1);

    if (first_pixel) begin
      res.code_value  = value;
      res.code_length = LEN_W'(cfg.depth);
    end else if (esc) begin
      res.code_value  = value;
      res.code_length = cfg.umax + LEN_W'(cfg.depth);
    end else begin
      res.code_value  = (kmask + 16'd1) | (value & kmask);
      res.code_length = LEN_W'(u) + 6'd1 + LEN_W'(k);
    end

    sum       = (ACC_W+1)'(acc) + (ACC_W+1)'(value);
    sum_rnd   = (ACC_W+2)'(sum) + 34'd1;
    cmax      = (17'd1 << cfg.cbits) - 17'd1;
    cnt_inc   = cnt + 17'd1;
    base      = (24'd3 << (cfg.kz + 5'd6)) - 24'd49;
    init_wide = 40'(base) << cfg.ice;

    if (first_pixel) begin
      res.acc_nxt = init_wide[38:7];
    end else if (cnt < cmax) begin
      res.acc_nxt = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    end else begin
      res.acc_nxt = sum_rnd[ACC_W:1];
    end

    if (first_pixel) begin
      res.cnt_nxt = 17'd1 << cfg.ice;
    end else if (last_band) begin
      res.cnt_nxt = (cnt < cmax) ? cnt_inc : (cnt_inc >> 1);
    end else begin
      res.cnt_nxt = cnt;
    end
  end

endmodule

FILE: src/sample_adaptive_golomb_encoder_core.sv
// Adaptive Golomb power-of-two residual coder. Each input word carries one
// mapped residual (tdata[15:0]), its band (tdata[23:16]) and the first-pixel
// flag (tuser); each output word carries one codeword: value in tdata[15:0],
// total length with leading zeros in tdata[21:16]. One word is accepted per
// clock while the output is not stalled; its codeword passes through the s1
// register and the output register. The rate is set by the per-band
// accumulator memory: it is read when a word enters, and the k search,
// codeword and accumulator update are done in s1 and written back when the
// word leaves s1, with the last write forwarded to a read of the same band.
// Accumulators read as zero after reset through per-entry valid bits, so there
// is no clearing pass. Write configuration only while no word is in flight.
`include "sample_adaptive_golomb_encoder_core_macros.svh"

module sample_adaptive_golomb_encoder_core
  import sage_pkg::*;
#(
  parameter int MAX_BANDS = SAGE_MAX_BANDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // delta[15:0], band[23:16]
  input  logic        in_tuser,   // first_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // code_value[15:0], code_length[21:16], zero
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int BAND_SPAN = 1 << BAND_W;
  localparam int MEM_DEPTH = (MAX_BANDS < BAND_SPAN) ? MAX_BANDS : BAND_SPAN;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  cfg_t               cfg_r;
  cfg_t               cfg_nxt;
  logic [AW-1:0]      slot_tab [BAND_SPAN];
  logic               in_acc;
  logic               adv;
  logic               fire;
  logic               s1_valid_r;
  logic [DELTA_W-1:0] s1_delta_r;
  logic [BAND_W-1:0]  s1_band_r;
  logic               s1_first_r;
  logic               s1_last;
  logic [CNT_W-1:0]   cnt_r;
  logic [ACC_W-1:0]   acc_rd;
  krn_out_t           krn;
  logic               out_valid_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [LEN_W-1:0]   out_len_r;

  // configuration, saturated on write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_DEPTH: begin
          cfg_nxt.depth = (cfg_data[4:0] == 5'd0) ? 5'd1 :
                          (cfg_data[4:0] > 5'd16) ? 5'd16 : cfg_data[4:0];
        end
        CFG_UNARY_LIMIT: begin
          cfg_nxt.umax = (cfg_data[5:0] == 6'd0) ? 6'd1 :
                         (cfg_data[5:0] > 6'd32) ? 6'd32 : cfg_data[5:0];
        end
        CFG_COUNTER_BITS: begin
          cfg_nxt.cbits = (cfg_data[4:0] == 5'd0) ? 5'd1 :
                          (cfg_data[4:0] > 5'd16) ? 5'd16 : cfg_data[4:0];
        end
        CFG_INIT_COUNT_EXP: begin
          cfg_nxt.ice = (cfg_data[4:0] > 5'd16) ? 5'd16 : cfg_data[4:0];
        end
        CFG_ACC_INIT_CONST: begin
          cfg_nxt.kz = (cfg_data[4:0] > 5'd16) ? 5'd16 : cfg_data[4:0];
        end
        CFG_BAND_COUNT: begin
          cfg_nxt.band_count = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth      <= 5'd16;
      cfg_r.umax       <= 6'd18;
      cfg_r.cbits      <= 5'd8;
      cfg_r.ice        <= 5'd6;
      cfg_r.kz         <= 5'd8;
      cfg_r.band_count <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // band to accumulator slot, band modulo MAX_BANDS
  for (genvar g = 0; g < BAND_SPAN; g++) begin : g_slot
    localparam int SlotVal = g % MAX_BANDS;
    assign slot_tab[g] = AW'(SlotVal);
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign fire      = s1_valid_r && adv;

  sage_acc_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (slot_tab[in_tdata[23:16]]),
    .wr_en   (fire),
    .wr_data (krn.acc_nxt),
    .rd_data (acc_rd)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_delta_r <= in_tdata[15:0];
      s1_band_r  <= in_tdata[23:16];
      s1_first_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // a band count of zero makes every band the last one
  assign s1_last = (cfg_r.band_count == 9'd0) ||
                   ((9'(s1_band_r) + 9'd1) >= cfg_r.band_count);

  sage_kernel u_kernel (
    .cfg         (cfg_r),
    .delta       (s1_delta_r),
    .first_pixel (s1_first_r),
    .last_band   (s1_last),
    .acc         (acc_rd),
    .cnt         (cnt_r),
    .res         (krn)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= krn.cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_code_r <= krn.code_value;
      out_len_r  <= krn.code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_code_r};

  `SAGE_ASSERT_NEXT(a_out_load, s1_valid_r && adv, out_valid_r)
  `SAGE_ASSERT_NOW(a_no_overrun, in_acc && out_valid_r && !out_tready, !s1_valid_r)
  `SAGE_ASSERT_NOW(a_cnt_bound, s1_valid_r || !s1_valid_r, cnt_r <= 17'h10000)
  `SAGE_ASSERT_NOW(a_len_range, out_valid_r, (out_len_r != 6'd0) && (out_len_r <= 6'd48))

endmodule

FILE: verif/sage_codeword_checker.sv
`timescale 1ns / 100ps

module sage_codeword_checker
  import sage_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // delta[15:0], band[23:16]
  input  logic        in_tuser,   // first_pixel
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // code_value[15:0], code_length[21:16]
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          mismatch_count,
  output int          codes_pending,
  output int          codes_seen
);

  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
  } codeword_t;

  codeword_t        expected_codes[$];
  codeword_t        want;
  logic [ACC_W-1:0] band_acc[SAGE_MAX_BANDS];
  logic [CNT_W-1:0] shared_cnt;
  logic [4:0]       depth_reg, cbits_reg, ice_reg, kz_reg;
  logic [5:0]       umax_reg;
  logic [8:0]       band_count_reg;

  function automatic int unsigned saturate_to(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [ACC_W-1:0] seed_accumulator();
    logic [63:0] base;
    base = (64'd3 << (saturate_to(kz_reg, 0, 16) + 6)) - 64'd49;
    // keep only the low 32 bits of the scaled seed
    return ACC_W'((base << saturate_to(ice_reg, 0, 16)) >> 7);
  endfunction

  function automatic int unsigned choose_k(input logic [CNT_W-1:0] cnt, input logic [63:0] bound,
                                           input int unsigned depth);
    int unsigned top, best, i;
    logic [63:0] wide_cnt;
    wide_cnt = 64'(cnt);
    top = (depth >= 2) ? depth - 2 : 0;
    best = 0;
    if ((wide_cnt << 1) > bound) return 0;
    for (i = 1; i <= top; i++) begin
      if ((wide_cnt << i) <= bound) best = i;
    end
    return best;
  endfunction

  function automatic void note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  task automatic encode_residual(input logic [15:0] delta, input logic [7:0] band,
                                 input logic first);
    int unsigned depth, umax, cbits, k, u;
    logic [31:0] cmax, value, code, len;
    logic [CNT_W-1:0] cnt;
    logic [ACC_W-1:0] acc;
    logic [63:0] bound, sum;
    codeword_t cw;
    depth = saturate_to(depth_reg, 1, 16);
    umax  = saturate_to(umax_reg, 1, 32);
    cbits = saturate_to(cbits_reg, 1, 16);
    cmax  = (32'd1 << cbits) - 32'd1;
    value = 32'(delta) & ((32'd1 << depth) - 32'd1);
    cnt   = shared_cnt;
    acc   = band_acc[band];
    bound = 64'(acc) + 64'((32'd49 * 32'(cnt)) >> 7);
    k     = choose_k(cnt, bound, depth);

    if (first) begin
      code = value;
      len  = depth;
    end else begin
      u = value >> k;
      if (u >= umax) begin
        // escape: full-width value after the zero run
        code = value;
        len  = umax + depth;
      end else begin
        code = (32'd1 << k) | (value & ((32'd1 << k) - 32'd1));
        len  = u + 1 + k;
      end
    end

    if (first) begin
      band_acc[band] = seed_accumulator();
      shared_cnt     = CNT_W'(32'd1 << saturate_to(ice_reg, 0, 16));
    end else begin
      sum = 64'(acc) + 64'(value);
      if (32'(cnt) < cmax) begin
        band_acc[band] = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
      end else begin
        band_acc[band] = ACC_W'((sum + 64'd1) >> 1);
      end
      if (int'(band) + 1 >= int'(band_count_reg)) begin
        shared_cnt = (32'(cnt) < cmax) ? CNT_W'(32'(cnt) + 1) : CNT_W'((32'(cnt) + 1) >> 1);
      end
    end

    cw.code_value  = code[CODE_W-1:0];
    cw.code_length = len[LEN_W-1:0];
    expected_codes.insert(expected_codes.size(), cw);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAGE_MAX_BANDS; i++) band_acc[i] = '0;
      shared_cnt     = '0;
      depth_reg      = 5'd16;
      umax_reg       = 6'd18;
      cbits_reg      = 5'd8;
      ice_reg        = 5'd6;
      kz_reg         = 5'd8;
      band_count_reg = 9'd256;
      expected_codes.delete();
      mismatch_count = 0;
      codes_seen     = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SAMPLE_DEPTH:   depth_reg      = cfg_data[4:0];
          CFG_UNARY_LIMIT:    umax_reg       = cfg_data[5:0];
          CFG_COUNTER_BITS:   cbits_reg      = cfg_data[4:0];
          CFG_INIT_COUNT_EXP: ice_reg        = cfg_data[4:0];
          CFG_ACC_INIT_CONST: kz_reg         = cfg_data[4:0];
          CFG_BAND_COUNT:     band_count_reg = cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          note_failure($sformatf("codeword %h/%0d with no residual pending",
                                 out_tdata[15:0], out_tdata[21:16]));
        end else begin
          want = expected_codes.pop_front();
          if (out_tdata[15:0] !== want.code_value || out_tdata[21:16] !== want.code_length) begin
            note_failure($sformatf("codeword mismatch: value exp %h got %h, length exp %0d got %0d",
                                   want.code_value, out_tdata[15:0],
                                   want.code_length, out_tdata[21:16]));
          end
        end
      end
      if (in_tvalid && in_tready) encode_residual(in_tdata[15:0], in_tdata[23:16], in_tuser);
    end
    codes_pending = expected_codes.size();
  end

endmodule

FILE: verif/sample_adaptive_golomb_encoder_core_tb.sv
`timescale 1ns / 100ps

module sample_adaptive_golomb_encoder_core_tb
  import sage_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // delta[15:0], band[23:16]
  logic        in_tuser;   // first_pixel
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // code_value[15:0], code_length[21:16], zero
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  int mismatch_count;
  int codes_pending;
  int codes_seen;
  int idle_cycles;
  int words_sent;

  sample_adaptive_golomb_encoder_core DUT (.*);

  sage_codeword_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .codes_pending  (codes_pending),
    .codes_seen     (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [15:0] delta, input logic [7:0] band, input logic first);
    while ((words_sent < 150 || words_sent >= 300) && $urandom_range(99) < 6) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {band, delta};
    in_tuser  = first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // drain before touching a register
  task automatic write_reg(input cfg_idx_t idx, input logic [8:0] value);
    while (codes_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_settings(input logic [8:0] depth, input logic [8:0] umax,
                                input logic [8:0] cbits, input logic [8:0] ice,
                                input logic [8:0] kz, input logic [8:0] bands);
    write_reg(CFG_SAMPLE_DEPTH, depth);
    write_reg(CFG_UNARY_LIMIT, umax);
    write_reg(CFG_COUNTER_BITS, cbits);
    write_reg(CFG_INIT_COUNT_EXP, ice);
    write_reg(CFG_ACC_INIT_CONST, kz);
    write_reg(CFG_BAND_COUNT, bands);
  endtask

  // one image-like run: first row of pixels flagged, bands in order, mostly small residuals
  task automatic send_image(input logic [8:0] bands);
    int nb, roll, w;
    logic [15:0] delta;
    logic [7:0] band;
    logic first;
    nb = (bands >= 1 && bands <= 256) ? int'(bands) : 256;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      roll  = $urandom_range(99);
      band  = 8'(n % nb);
      first = (n < nb);
      w     = $urandom_range(16);
      delta = ($urandom_range(99) < 15) ? 16'($urandom) : 16'($urandom & ((32'd1 << w) - 1));
      if (roll < 8) band = 8'($urandom);
      else if (roll < 12) first = 1'($urandom_range(1));
      send_word(delta, band, first);
    end
  endtask

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    words_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // counter still zero: k at its top
    send_word(16'hFFFF, 8'h00, 1'b0);
    // last band advances the shared counter
    send_word(16'h0000, 8'hFF, 1'b0);
    send_word(16'hFFFF, 8'h80, 1'b1);
    // large residual escapes
    send_word(16'hFFFF, 8'h80, 1'b0);
    send_word(16'h0003, 8'h80, 1'b0);
    send_word(16'h5A5A, 8'h7F, 1'b1);

    // zero depth and zero limit act as their lowest values
    write_reg(CFG_SAMPLE_DEPTH, 9'd0);
    write_reg(CFG_UNARY_LIMIT, 9'd0);
    send_word(16'hFFFF, 8'h01, 1'b1);
    send_word(16'hFFFE, 8'h01, 1'b0);
    send_word(16'h0001, 8'h01, 1'b0);

    // oversized values saturate; band count zero makes every band last
    write_reg(CFG_SAMPLE_DEPTH, 9'd31);
    write_reg(CFG_UNARY_LIMIT, 9'd63);
    write_reg(CFG_COUNTER_BITS, 9'd0);
    write_reg(CFG_BAND_COUNT, 9'd0);
    send_word(16'h8001, 8'h02, 1'b1);
    send_word(16'hFFFF, 8'h02, 1'b0);
    send_word(16'h1234, 8'h03, 1'b0);
    send_word(16'h0000, 8'h02, 1'b0);

    // truncated seed accumulator, counter never advances
    write_reg(CFG_COUNTER_BITS, 9'd31);
    write_reg(CFG_INIT_COUNT_EXP, 9'd31);
    write_reg(CFG_ACC_INIT_CONST, 9'd31);
    write_reg(CFG_BAND_COUNT, 9'd511);
    send_word(16'hFFFF, 8'hFE, 1'b1);
    send_word(16'hFFFF, 8'hFE, 1'b0);
    send_word(16'h00FF, 8'hFE, 1'b0);

    write_reg(CFG_INIT_COUNT_EXP, 9'd0);
    write_reg(CFG_ACC_INIT_CONST, 9'd0);
    send_word(16'h7FFF, 8'h04, 1'b1);
    send_word(16'h0000, 8'h04, 1'b0);
    send_word(16'hFFFF, 8'h04, 1'b0);

    words_sent = 0;
    apply_settings(9'd16, 9'd32, 9'd16, 9'd0, 9'd0, 9'd256);
    send_image(9'd256);
    apply_settings(9'd1, 9'd1, 9'd1, 9'd16, 9'd16, 9'd1);
    send_image(9'd1);
    for (int p = 0; p < 4; p++) begin
      apply_settings(9'($urandom_range(2, 16)), 9'($urandom_range(1, 32)),
                     9'($urandom_range(2, 16)), 9'($urandom_range(16)),
                     9'($urandom_range(16)),
                     9'((p == 3) ? $urandom_range(1, 256) : $urandom_range(1, 16)));
      send_image(cfg_data);
    end
    // raw register values, out-of-range ones included
    apply_settings(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
                   9'($urandom_range(1, 16)));
    send_image(cfg_data);

    while (codes_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && codes_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : sink
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && codes_seen >= 300) begin
        // hold off so the block backs up into its input
        held = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready = (codes_seen >= 450 && codes_seen < 600) || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
